// ===== design/hsk_pkg.sv =====
// ----------------------------------------------------------------------------
// hsk_pkg
// Shared types and constants for the heading and speed kinematics stepper.
// ----------------------------------------------------------------------------
package hsk_pkg;

  localparam int SINE_DEPTH_DEFAULT = 256;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [15:0] TIME_STEP_RESET = 16'd655;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {
    OP_COMMAND = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } opcode_t;

  localparam logic [2:0] MOT_NONE   = 3'd0;
  localparam logic [2:0] MOT_TURN   = 3'd1;
  localparam logic [2:0] MOT_ACCEL  = 3'd2;
  localparam logic [2:0] MOT_MOVING = 3'd3;
  localparam logic [2:0] MOT_DECEL  = 3'd4;

  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd0;
  localparam logic [2:0] REG_ACCELERATION  = 3'd1;
  localparam logic [2:0] REG_TURN_RATE     = 3'd2;
  localparam logic [2:0] REG_TIME_STEP     = 3'd3;
  localparam logic [2:0] REG_START_X       = 3'd4;
  localparam logic [2:0] REG_START_Y       = 3'd5;
  localparam logic [2:0] REG_START_HEADING = 3'd6;

endpackage

// ===== design/hsk_sine_rom.sv =====
// ----------------------------------------------------------------------------
// hsk_sine_rom
// Quarter-wave sine table in Q1.15, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module hsk_sine_rom #(
  parameter int SINE_TABLE_DEPTH = hsk_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic [$clog2(SINE_TABLE_DEPTH+1)-1:0] addr,
  output logic [15:0]                         data
);
  import hsk_pkg::*;

  logic [15:0] tab [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_ent
    localparam logic [63:0] X  = (64'(k) * PI_HALF_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam logic signed [63:0] S = $signed(X) - $signed(T1) + $signed(T2)
      - $signed(T3) + $signed(T4) - $signed(T5) + $signed(T6) - $signed(T7);
    localparam logic [63:0] SC = (S < 0) ? 64'd0 : $unsigned(S);
    localparam logic [63:0] E  = (SC + 64'd16384) >> 15;
    assign tab[k] = E[15:0];
  end

  always_ff @(posedge clk) begin
    data <= tab[addr];
  end

endmodule

// ===== design/heading_speed_kinematics_step.sv =====
// ----------------------------------------------------------------------------
// heading_speed_kinematics_step
// Heading and speed kinematics stepper with a shared multiplier sequencer.
// ----------------------------------------------------------------------------
// Items arrive on the in channel (in_valid/in_ready) and carry an opcode.
// A command or a restart is taken while idle and returns no item.
// A tick runs a sequencer around one shared 32x24 multiplier and one sine
// table port: speed step, turn step, two table reads, then speed times
// cosine, times step, speed times sine, times step. A tick returns one
// telemetry item on the out channel (out_valid/out_ready) after the last
// step, and holds it there until the receiver takes it.
// The in channel is not ready while a tick is in work or its result waits.
// A stalled receiver holds the result and the motion state unchanged.
// Configuration writes (cfg_valid/cfg_ready) are always ready, act at once;
// the user must make them only while idle; the block does not enforce it.
// Reset clears config and motion state, sets time_step to 655, and leaves
// the block idle and ready. The sine table needs no fill after reset.
// ----------------------------------------------------------------------------
module heading_speed_kinematics_step #(
  parameter int SINE_TABLE_DEPTH = hsk_pkg::SINE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [2:0]         motion,
  input  logic [15:0]        target_heading,
  input  logic               seed_valid,
  input  logic [31:0]        turn_seed,
  input  logic [15:0]        tick_length,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic [15:0]        speed,
  output logic signed [16:0] vel_x,
  output logic signed [16:0] vel_y,
  output logic [31:0]        turn_left,
  output logic [39:0]        elapsed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hsk_pkg::*;

  localparam int AW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_DV    = 12'b000000000010,
    S_STP   = 12'b000000000100,
    S_STEER = 12'b000000001000,
    S_ACOS  = 12'b000000010000,
    S_ASIN  = 12'b000000100000,
    S_MCX   = 12'b000001000000,
    S_MDX   = 12'b000010000000,
    S_MCY   = 12'b000100000000,
    S_MDY   = 12'b001000000000,
    S_MVY   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0] speed_limit;
  logic [15:0] acceleration;
  logic [23:0] turn_rate;
  logic [15:0] time_step;
  logic [31:0] start_x;
  logic [31:0] start_y;
  logic [15:0] start_heading;

  logic [31:0] x_position;
  logic [31:0] y_position;
  logic [15:0] heading_now;
  logic [15:0] speed_now;
  logic [31:0] turn_time_left;
  logic [39:0] elapsed_clock;
  logic [2:0]  latched_motion;
  logic [15:0] latched_target;

  logic [55:0] prod;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [15:0] cos_mag;
  logic        cos_neg;
  logic [15:0] sin_mag;
  logic        sin_neg;
  logic [16:0] vx;
  logic [16:0] vy;

  logic [15:0]    rom_h;
  logic [AW+13:0] idx_prod;
  logic [AW-1:0]  idx;
  logic [AW-1:0]  rom_addr;
  logic [15:0]    rom_data;

  logic        in_fire;
  logic [15:0] dv;
  logic [16:0] speed_sum;
  logic [23:0] stp;
  logic [15:0] herr;
  logic [16:0] emag;
  logic [16:0] stp_c;
  logic        steer_on;
  logic        cruise_on;
  logic [16:0] vr;
  logic [31:0] mr;
  logic [31:0] mdelta;

  hsk_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk (clk),
    .addr(rom_addr),
    .data(rom_data)
  );

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  assign pos_x     = $signed(x_position);
  assign pos_y     = $signed(y_position);
  assign heading   = heading_now;
  assign speed     = speed_now;
  assign vel_x     = $signed(vx);
  assign vel_y     = $signed(vy);
  assign turn_left = turn_time_left;
  assign elapsed   = elapsed_clock;

  always_comb begin
    rom_h    = (state == S_ACOS) ? heading_now + QUARTER_TURN : heading_now;
    idx_prod = (AW+14)'(rom_h[13:0]) * (AW+14)'(SINE_TABLE_DEPTH);
    idx      = idx_prod[AW+13:14];
    rom_addr = rom_h[14] ? AW'(SINE_TABLE_DEPTH) - idx : idx;
  end

  always_comb begin
    unique case (state)
      S_DV: begin
        mul_a = 32'(acceleration);
        mul_b = 24'(time_step);
      end
      S_STP: begin
        mul_a = 32'(turn_rate);
        mul_b = 24'(time_step);
      end
      S_MCX: begin
        mul_a = 32'(speed_now);
        mul_b = 24'(cos_mag);
      end
      S_MCY: begin
        mul_a = 32'(speed_now);
        mul_b = 24'(sin_mag);
      end
      default: begin
        mul_a = prod[31:0];
        mul_b = 24'(time_step);
      end
    endcase
  end

  always_comb begin
    dv        = prod[31:16];
    speed_sum = 17'(speed_now) + 17'(dv);
    stp       = prod[39:16];
    herr      = latched_target - heading_now;
    emag      = herr[15] ? 17'h10000 - 17'(herr) : 17'(herr);
    stp_c     = (25'(stp) > 25'(emag)) ? emag : stp[16:0];
    steer_on  = (latched_motion == MOT_TURN) ||
                (((latched_motion == MOT_ACCEL) || (latched_motion == MOT_MOVING)) &&
                 (emag > 17'd1));
    cruise_on = (latched_motion == MOT_ACCEL) || (latched_motion == MOT_MOVING) ||
                (latched_motion == MOT_DECEL);
    vr        = {1'b0, prod[30:15]};
    mr        = 32'(prod[55:31]);
    mdelta    = ((state == S_MCY) ? cos_neg : sin_neg) ? 32'd0 - mr : mr;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_fire && (opcode == OP_TICK)) state_next = S_DV;
      S_DV:    state_next = S_STP;
      S_STP:   state_next = S_STEER;
      S_STEER: state_next = S_ACOS;
      S_ACOS:  state_next = S_ASIN;
      S_ASIN:  state_next = S_MCX;
      S_MCX:   state_next = S_MDX;
      S_MDX:   state_next = S_MCY;
      S_MCY:   state_next = S_MDY;
      S_MDY:   state_next = S_MVY;
      S_MVY:   state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit   <= '0;
      acceleration  <= '0;
      turn_rate     <= '0;
      time_step     <= TIME_STEP_RESET;
      start_x       <= '0;
      start_y       <= '0;
      start_heading <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPEED_LIMIT:   speed_limit   <= cfg_data[15:0];
        REG_ACCELERATION:  acceleration  <= cfg_data[15:0];
        REG_TURN_RATE:     turn_rate     <= cfg_data[23:0];
        REG_TIME_STEP:     time_step     <= cfg_data[15:0];
        REG_START_X:       start_x       <= cfg_data;
        REG_START_Y:       start_y       <= cfg_data;
        REG_START_HEADING: start_heading <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 56'(mul_a) * 56'(mul_b);
    if (state == S_ASIN) begin
      cos_mag <= rom_data;
    end
    if (state == S_ACOS) begin
      cos_neg <= rom_h[15];
    end
    if (state == S_MCX) begin
      sin_mag <= rom_data;
      sin_neg <= heading_now[15];
    end
    if (state == S_MDX) begin
      vx <= cos_neg ? 17'd0 - vr : vr;
    end
    if (state == S_MDY) begin
      vy <= sin_neg ? 17'd0 - vr : vr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position     <= '0;
      y_position     <= '0;
      heading_now    <= '0;
      speed_now      <= '0;
      turn_time_left <= '0;
      elapsed_clock  <= '0;
      latched_motion <= MOT_NONE;
      latched_target <= '0;
    end else begin
      if (in_fire) begin
        unique case (opcode)
          OP_COMMAND: begin
            latched_motion <= motion;
            latched_target <= target_heading;
            if (seed_valid) begin
              turn_time_left <= turn_seed;
            end
          end
          OP_TICK: begin
            elapsed_clock <= elapsed_clock + 40'(tick_length);
          end
          OP_RESTART: begin
            x_position     <= start_x;
            y_position     <= start_y;
            heading_now    <= start_heading;
            speed_now      <= '0;
            turn_time_left <= '0;
            elapsed_clock  <= '0;
          end
          default: ;
        endcase
      end
      if (state == S_STP) begin
        if (latched_motion == MOT_ACCEL) begin
          speed_now <= (speed_sum > 17'(speed_limit)) ? speed_limit : speed_sum[15:0];
        end else if (latched_motion == MOT_DECEL) begin
          speed_now <= (speed_now > dv) ? speed_now - dv : 16'd0;
        end
      end
      if (state == S_STEER) begin
        if (steer_on) begin
          heading_now <= (!herr[15] && (herr != 16'd0)) ? heading_now + stp_c[15:0]
                                                        : heading_now - stp_c[15:0];
        end
        if (latched_motion == MOT_TURN) begin
          turn_time_left <= (turn_time_left > 32'(time_step)) ?
                            turn_time_left - 32'(time_step) : 32'd0;
        end
      end
      if ((state == S_MCY) && cruise_on) begin
        x_position <= x_position + mdelta;
      end
      if ((state == S_MVY) && cruise_on) begin
        y_position <= y_position + mdelta;
      end
    end
  end

`ifndef SYNTHESIS
  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result waits");
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode == OP_TICK)) |=> !in_ready)
    else $error("tick did not start the sequencer");
  a_other_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (opcode != OP_TICK)) |=> (in_ready && !out_valid))
    else $error("non-tick item caused a result");
`endif

endmodule
